### hw/rtl/modal_resonator_filter_unit_assert.svh
// Assertion macros for the modal resonator filter unit.
// Expects clk and arst_n in the scope of each use.
`ifndef MODAL_RESONATOR_FILTER_UNIT_ASSERT_SVH
`define MODAL_RESONATOR_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define MRF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mrf_pkg.sv
// Shared types and constants for the modal resonator filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package mrf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int FREQ_W   = 15;
	localparam int QUAL_W   = 14;
	localparam int RATE_W   = 18;
	localparam int CFG_W    = 18;
	localparam int IDX_W    = 2;
	localparam int COEF_W   = 32;
	localparam int STATE_W  = 48;
	localparam int SUM_W    = 52;
	localparam int ALPHA_W  = 32;
	localparam int GAIN_W   = 31;
	localparam int BETA_W   = 58;
	localparam int DQ_W     = 49;
	localparam int DEN_W    = 59;
	localparam int DVD_W    = 88;
	localparam int DVS_W    = 64;
	localparam int QUO_W    = 64;
	localparam int MAG_W    = 80;
	localparam int CNT_W    = $clog2(DVD_W);
	localparam int RATIO_FRAC = 34;

	localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;
	localparam logic [FREQ_W-1:0] FREQ_RST = 15'd500;
	localparam logic [QUAL_W-1:0] QUAL_RST = 14'd800;
	localparam logic [RATE_W-1:0] RATE_RST = 18'd48000;
	localparam logic [DEN_W-1:0] RATIO_ONE = 59'd1 << RATIO_FRAC;
	localparam logic signed [SUM_W-1:0] Y_HI = 52'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] Y_LO = 52'shF_8000_0000_0000;

	typedef enum logic [IDX_W-1:0] {
		REG_FREQ = 2'd0,
		REG_QUAL = 2'd1,
		REG_RATE = 2'd2
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_KMUL, OP_ADIV, OP_ALPHA, OP_BMUL, OP_DQDIV, OP_DQCAP,
		OP_A0DIV, OP_A0CAP, OP_A1DIV, OP_A1CAP, OP_A2DIV, OP_A2CAP,
		OP_T0, OP_T1L, OP_T1H, OP_T2L, OP_T2H, OP_Y, OP_OL, OP_OH, OP_OF
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load_x;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_full;
		logic cfg_hit;
	} sts_t;

endpackage
`default_nettype wire

### hw/rtl/mrf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on mrf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrf_div import mrf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic [QUO_W-1:0]      quotient,
	output logic                  overflow
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic             ovf_q;
	logic [DVS_W:0]   rsh;
	logic [DVS_W:0]   rdiff;
	logic             ge;

	assign rsh   = {rem_q, dvd_q[DVD_W-1]};
	assign rdiff = rsh - {1'b0, dvs_q};
	assign ge    = rsh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? rdiff[DVS_W-1:0] : rsh[DVS_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[QUO_W-1];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
	assign overflow = ovf_q;

endmodule
`default_nettype wire

### hw/rtl/mrf_datapath.sv
// Datapath: config registers, coefficients, delay line, shared multiplier and divider.
// Depends on mrf_pkg and mrf_div; driven by commands from mrf_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module mrf_datapath import mrf_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_data,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic                       out_ready,
	input  wire cmd_t                       cmd,
	output sts_t                            sts,
	output logic                            out_valid,
	output logic signed [SAMPLE_W-1:0]      sample_out
);

	logic [FREQ_W-1:0] freq_q;
	logic [QUAL_W-1:0] qual_q;
	logic [RATE_W-1:0] rate_q;

	logic [ALPHA_W-1:0] alpha_q;
	logic [BETA_W-1:0]  beta_q;
	logic [DQ_W-1:0]    dq_q;
	logic signed [COEF_W-1:0] a0_q, a1_q, a2_q;

	logic signed [SAMPLE_W-1:0] x_in_q, x_prev_q;
	logic signed [STATE_W-1:0]  y1_q, y2_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [63:0] prod_q, macc_q;
	logic        out_valid_q;
	logic signed [SAMPLE_W-1:0] out_data_q;

	logic [FREQ_W-1:0] f_eff;
	logic [QUAL_W-1:0] q_eff;
	logic [GAIN_W-1:0] d_w;
	logic [DEN_W-1:0]  den_w, two_beta, beta_x, dq_x, num_w;
	logic              num_neg;
	logic              div_start, div_busy, div_ovf;
	logic [DVD_W-1:0]  div_dvd;
	logic [DVS_W-1:0]  div_dvs;
	logic [QUO_W-1:0]  div_quo;
	logic [ALPHA_W-1:0] alpha_w;
	logic [COEF_W-2:0] rmag;
	logic signed [COEF_W-1:0] rcoef;

	logic [31:0] a0m, a1m, a2m, mul_a, mul_b;
	logic [SAMPLE_W-1:0] xm;
	logic [STATE_W-1:0]  y1m, y2m;
	logic [63:0] mul_p;
	logic        mul_en;
	logic [MAG_W-1:0] full;
	logic [34:0] t0m;
	logic [50:0] tfm;
	logic [42:0] om;
	logic        tneg;
	logic signed [SUM_W-1:0] t0s, tfs, y_raw;
	logic signed [STATE_W-1:0] y_sat;
	logic signed [SAMPLE_W-1:0] o_sat;
	logic out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RST;
			qual_q <= QUAL_RST;
			rate_q <= RATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FREQ: freq_q <= cfg_data[FREQ_W-1:0];
				REG_QUAL: qual_q <= cfg_data[QUAL_W-1:0];
				REG_RATE: rate_q <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	assign f_eff    = (freq_q == '0) ? FREQ_W'(1) : freq_q;
	assign q_eff    = (qual_q == '0) ? QUAL_W'(1) : qual_q;
	assign d_w      = alpha_q[ALPHA_W-1:1];
	assign beta_x   = DEN_W'(beta_q);
	assign dq_x     = DEN_W'(dq_q);
	assign den_w    = beta_x + dq_x;
	assign two_beta = {beta_q, 1'b0};

	always_comb begin
		num_w   = '0;
		num_neg = 1'b0;
		case (cmd.op) inside
			OP_A0DIV, OP_A0CAP: num_w = RATIO_ONE;
			OP_A1DIV, OP_A1CAP: begin
				if (two_beta > RATIO_ONE) begin
					num_w   = two_beta - RATIO_ONE;
					num_neg = 1'b1;
				end else begin
					num_w = RATIO_ONE - two_beta;
				end
			end
			OP_A2DIV, OP_A2CAP: begin
				if (dq_x > beta_x) begin
					num_w   = dq_x - beta_x;
					num_neg = 1'b1;
				end else begin
					num_w = beta_x - dq_x;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		case (cmd.op) inside
			OP_ADIV: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'({rate_q, 44'b0});
				div_dvs   = DVS_W'(prod_q[41:0]);
			end
			OP_DQDIV: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'({d_w, 18'b0});
				div_dvs   = DVS_W'(q_eff);
			end
			OP_A0DIV, OP_A1DIV, OP_A2DIV: begin
				div_start = 1'b1;
				div_dvd   = {num_w, 29'b0};
				div_dvs   = DVS_W'(den_w);
			end
			default: ;
		endcase
	end

	mrf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo),
		.overflow (div_ovf)
	);

	assign alpha_w = (div_ovf || (|div_quo[QUO_W-1:ALPHA_W])) ? '1 : div_quo[ALPHA_W-1:0];

	always_comb begin
		rmag = (div_ovf || (|div_quo[QUO_W-1:COEF_W-1])) ? '1 : div_quo[COEF_W-2:0];
		if (num_w == '0 && den_w == '0) rmag = '0;
		rcoef = num_neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
	end

	assign a0m = a0_q[COEF_W-1] ? 32'(-a0_q) : 32'(a0_q);
	assign a1m = a1_q[COEF_W-1] ? 32'(-a1_q) : 32'(a1_q);
	assign a2m = a2_q[COEF_W-1] ? 32'(-a2_q) : 32'(a2_q);
	assign xm  = x_prev_q[SAMPLE_W-1] ? SAMPLE_W'(-x_prev_q) : SAMPLE_W'(x_prev_q);
	assign y1m = y1_q[STATE_W-1] ? STATE_W'(-y1_q) : STATE_W'(y1_q);
	assign y2m = y2_q[STATE_W-1] ? STATE_W'(-y2_q) : STATE_W'(y2_q);

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (cmd.op)
			OP_KMUL: begin mul_a = 32'(f_eff); mul_b = 32'(TWO_PI_Q24); end
			OP_BMUL: begin mul_a = alpha_q; mul_b = alpha_q; end
			OP_T0:   begin mul_a = a0m; mul_b = 32'(xm); end
			OP_T1L:  begin mul_a = a1m; mul_b = y1m[31:0]; end
			OP_T1H:  begin mul_a = a1m; mul_b = 32'(y1m[STATE_W-1:32]); end
			OP_T2L:  begin mul_a = a2m; mul_b = y2m[31:0]; end
			OP_T2H:  begin mul_a = a2m; mul_b = 32'(y2m[STATE_W-1:32]); end
			OP_OL:   begin mul_a = 32'(d_w); mul_b = y1m[31:0]; end
			OP_OH:   begin mul_a = 32'(d_w); mul_b = 32'(y1m[STATE_W-1:32]); end
			default: mul_en = 1'b0;
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);

	assign full = MAG_W'(macc_q) + {prod_q[47:0], 32'b0};
	assign t0m  = prod_q[46:12];
	assign tfm  = full[MAG_W-1:29];
	assign om   = full[MAG_W-1:37];
	assign tneg = (cmd.op == OP_Y) ? (a2_q[COEF_W-1] ^ y2_q[STATE_W-1])
	                               : (a1_q[COEF_W-1] ^ y1_q[STATE_W-1]);
	assign t0s  = (a0_q[COEF_W-1] ^ x_prev_q[SAMPLE_W-1]) ? -$signed(SUM_W'(t0m))
	                                                      : $signed(SUM_W'(t0m));
	assign tfs  = tneg ? -$signed(SUM_W'(tfm)) : $signed(SUM_W'(tfm));
	assign y_raw = sum_q - tfs;

	always_comb begin
		if (y_raw > Y_HI) y_sat = STATE_W'(Y_HI);
		else if (y_raw < Y_LO) y_sat = STATE_W'(Y_LO);
		else y_sat = y_raw[STATE_W-1:0];
	end

	always_comb begin
		if (!y1_q[STATE_W-1]) o_sat = (om > 43'd32767) ? 16'sh7FFF : $signed(om[15:0]);
		else o_sat = (om > 43'd32768) ? 16'sh8000 : $signed(16'(-om[15:0]));
	end

	assign out_full = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_x) x_in_q <= sample_in;
		if (mul_en) prod_q <= mul_p;
		case (cmd.op)
			OP_ALPHA: alpha_q <= alpha_w;
			OP_DQDIV: beta_q  <= prod_q[63:6];
			OP_DQCAP: dq_q    <= div_quo[DQ_W-1:0];
			OP_A0CAP: a0_q    <= rcoef;
			OP_A1CAP: a1_q    <= rcoef;
			OP_A2CAP: a2_q    <= rcoef;
			OP_T1L:   sum_q   <= t0s;
			OP_T2L:   sum_q   <= y_raw;
			OP_T1H, OP_T2H, OP_OH: macc_q <= prod_q;
			default: ;
		endcase
		if (cmd.op == OP_OF && !out_full) out_data_q <= o_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_prev_q    <= '0;
			y1_q        <= '0;
			y2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_Y) begin
				x_prev_q <= x_in_q;
				y2_q     <= y1_q;
				y1_q     <= y_sat;
			end
			if (cmd.op == OP_OF && !out_full) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign sts.div_busy = div_busy;
	assign sts.out_full = out_full;
	assign sts.cfg_hit  = cfg_we && (cfg_index == REG_FREQ || cfg_index == REG_QUAL ||
	                                 cfg_index == REG_RATE);
	assign out_valid  = out_valid_q;
	assign sample_out = out_data_q;

endmodule
`default_nettype wire

### hw/rtl/mrf_ctrl.sv
// Controller: sequences coefficient recompute and per-sample filter steps.
// Depends on mrf_pkg; issues commands to mrf_datapath.
`timescale 1ns / 1ps
`default_nettype none
module mrf_ctrl import mrf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire sts_t sts,
	output logic      in_ready,
	output cmd_t      cmd
);

	typedef enum logic [26:0] {
		S_IDLE   = 27'b1 << 0,
		S_KMUL   = 27'b1 << 1,
		S_ADIV   = 27'b1 << 2,
		S_AWAIT  = 27'b1 << 3,
		S_ALPHA  = 27'b1 << 4,
		S_BMUL   = 27'b1 << 5,
		S_DQDIV  = 27'b1 << 6,
		S_DQWAIT = 27'b1 << 7,
		S_DQCAP  = 27'b1 << 8,
		S_A0DIV  = 27'b1 << 9,
		S_A0WAIT = 27'b1 << 10,
		S_A0CAP  = 27'b1 << 11,
		S_A1DIV  = 27'b1 << 12,
		S_A1WAIT = 27'b1 << 13,
		S_A1CAP  = 27'b1 << 14,
		S_A2DIV  = 27'b1 << 15,
		S_A2WAIT = 27'b1 << 16,
		S_A2CAP  = 27'b1 << 17,
		S_T0     = 27'b1 << 18,
		S_T1L    = 27'b1 << 19,
		S_T1H    = 27'b1 << 20,
		S_T2L    = 27'b1 << 21,
		S_T2H    = 27'b1 << 22,
		S_Y      = 27'b1 << 23,
		S_OL     = 27'b1 << 24,
		S_OH     = 27'b1 << 25,
		S_OF     = 27'b1 << 26
	} state_t;

	state_t state_q, state_d;
	logic   coef_valid_q;
	op_t    op;

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = coef_valid_q ? S_T0 : S_KMUL;
			S_KMUL:   begin op = OP_KMUL;  state_d = S_ADIV; end
			S_ADIV:   begin op = OP_ADIV;  state_d = S_AWAIT; end
			S_AWAIT:  if (!sts.div_busy) state_d = S_ALPHA;
			S_ALPHA:  begin op = OP_ALPHA; state_d = S_BMUL; end
			S_BMUL:   begin op = OP_BMUL;  state_d = S_DQDIV; end
			S_DQDIV:  begin op = OP_DQDIV; state_d = S_DQWAIT; end
			S_DQWAIT: if (!sts.div_busy) state_d = S_DQCAP;
			S_DQCAP:  begin op = OP_DQCAP; state_d = S_A0DIV; end
			S_A0DIV:  begin op = OP_A0DIV; state_d = S_A0WAIT; end
			S_A0WAIT: if (!sts.div_busy) state_d = S_A0CAP;
			S_A0CAP:  begin op = OP_A0CAP; state_d = S_A1DIV; end
			S_A1DIV:  begin op = OP_A1DIV; state_d = S_A1WAIT; end
			S_A1WAIT: if (!sts.div_busy) state_d = S_A1CAP;
			S_A1CAP:  begin op = OP_A1CAP; state_d = S_A2DIV; end
			S_A2DIV:  begin op = OP_A2DIV; state_d = S_A2WAIT; end
			S_A2WAIT: if (!sts.div_busy) state_d = S_A2CAP;
			S_A2CAP:  begin op = OP_A2CAP; state_d = S_T0; end
			S_T0:     begin op = OP_T0;  state_d = S_T1L; end
			S_T1L:    begin op = OP_T1L; state_d = S_T1H; end
			S_T1H:    begin op = OP_T1H; state_d = S_T2L; end
			S_T2L:    begin op = OP_T2L; state_d = S_T2H; end
			S_T2H:    begin op = OP_T2H; state_d = S_Y; end
			S_Y:      begin op = OP_Y;   state_d = S_OL; end
			S_OL:     begin op = OP_OL;  state_d = S_OH; end
			S_OH:     begin op = OP_OH;  state_d = S_OF; end
			S_OF: begin
				op = OP_OF;
				if (!sts.out_full) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			coef_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sts.cfg_hit) coef_valid_q <= 1'b0;
			else if (state_q == S_A2CAP) coef_valid_q <= 1'b1;
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.op     = op;
	assign cmd.load_x = in_valid && in_ready;

endmodule
`default_nettype wire

### hw/rtl/modal_resonator_filter_unit.sv
// Usage: two-pole modal resonator on one Q1.15 audio sample per transaction.
// Input on s_axis_*, result on m_axis_*, coefficients set through cfg_we/cfg_index/cfg_data
// (0: center frequency, 1: quality in sixteenths, 2: sample rate; index 3 is ignored).
// Write configuration only while idle; a write marks the coefficients stale.
// One sample is in flight at a time: s_axis_tready is high only while idle.
// With current coefficients an accepted sample steps through T0, T1L, T1H, T2L, T2H, Y,
// OL, OH and OF before m_axis_tvalid rises; the single
// shared 32x32 multiplier forms seven products per sample (48-bit delayed outputs take
// two passes each).
// The first sample after reset or a register write first recomputes the
// coefficients: five shift-subtract divisions of an 88-bit dividend, one
// quotient bit per cycle, plus the multiply and capture steps.
// Reset clears the delay line, the output valid flag and the coefficient-valid flag;
// registers return to 500 Hz, Q = 50, 48 kHz.
// The result waits in an output register; while m_axis_tready is low the block
// may accept the next sample and works it up to the final step, then holds there.
`timescale 1ns / 1ps
`default_nettype none
`include "modal_resonator_filter_unit_assert.svh"
module modal_resonator_filter_unit import mrf_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample_in
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [SAMPLE_W-1:0]      m_axis_tdata,   // [15:0] sample_out
	input  wire logic                cfg_we,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic signed [SAMPLE_W-1:0] sample_out;

	mrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	mrf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  ($signed(s_axis_tdata)),
		.out_ready  (m_axis_tready),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_axis_tvalid),
		.sample_out (sample_out)
	);

	assign m_axis_tdata = sample_out;

	`MRF_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second sample accepted while busy")
	`MRF_ASSERT_NOW(a_div_not_idle, sts.div_busy, !s_axis_tready, "divider running while idle")
	`MRF_ASSERT_NEXT(a_result_loaded, cmd.op == OP_OF && !sts.out_full, m_axis_tvalid, "result step did not load output")

endmodule
`default_nettype wire
